### hw/rtl/trapezoidal_motion_profile_macros.svh
// assertion macros shared by the motion profile rtl
`ifndef TRAPEZOIDAL_MOTION_PROFILE_MACROS_SVH
`define TRAPEZOIDAL_MOTION_PROFILE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TMP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("motion profile assertion failed");
`define TMP_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("motion profile forbidden condition seen");
`else
`define TMP_ASSERT(lbl, prop)
`define TMP_ASSERT_NEVER(lbl, expr)
`endif
`endif

### hw/rtl/tmp_pkg.sv
// ----------------------------------------------------------------------------
// tmp_pkg
// shared widths, codes and constants of the motion profile unit
// ----------------------------------------------------------------------------
package tmp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int REG_W     = 31;
  localparam int PHASE_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_W     = 64;
  localparam int DSR_W     = 33;

  localparam logic OP_PLAN   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_VMAX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMAX = 1'b1;

  localparam logic [PHASE_W-1:0] PH_BEFORE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ACCEL    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CRUISE   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DECEL    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_FINISHED = 3'd4;

  localparam logic [REG_W-1:0] REG_ONE = REG_W'(1) << FRAC_BITS;

endpackage

### hw/rtl/tmp_divider.sv
// ----------------------------------------------------------------------------
// tmp_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "trapezoidal_motion_profile_macros.svh"
module tmp_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tmp_pkg::DIV_W-1:0]   dividend_i,
  input  logic [tmp_pkg::DSR_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [tmp_pkg::DIV_W-1:0]   quotient_o
);
  import tmp_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DSR_W:0]   shifted;
  logic [DSR_W:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    ge      = shifted >= {1'b0, dsr_q};
    diff    = shifted - {1'b0, dsr_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
      cnt_d  = CNT_W'(DIV_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `TMP_ASSERT(a_done_not_busy, done_q |-> !busy_q)
  `TMP_ASSERT_NEVER(a_no_restart, start_i && busy_q)
  `TMP_ASSERT(a_rem_below_divisor, busy_q |-> (rem_q < dsr_q))

endmodule

### hw/rtl/trapezoidal_motion_profile.sv
// ----------------------------------------------------------------------------
// trapezoidal_motion_profile
// plans triangular or trapezoidal moves and samples them, Q16.16 fixed point
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  cfg      | cfg_we_i                  | cfg_index_i, cfg_data_i
//  in       | in_valid_i / in_ready_o   | operation_i, move_distance_i, sample_time_i
//  out      | out_valid_o / out_ready_i | position_o .. triangular_o
//
//  one transaction at a time: in_ready_o is high only while the sequencer idles
//  a sample runs through a chain of steps on the shared multiplier
//  a triangular plan runs one divide and then an integer square root
//  a trapezoidal plan runs three divides
//  the output register holds a finished result under stall while a new
//  transaction is taken; no clearing pass after reset
`include "trapezoidal_motion_profile_macros.svh"
module trapezoidal_motion_profile (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tmp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tmp_pkg::REG_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic signed [tmp_pkg::DATA_W-1:0]  move_distance_i,
  input  logic signed [tmp_pkg::DATA_W-1:0]  sample_time_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [tmp_pkg::DATA_W-1:0]  position_o,
  output logic signed [tmp_pkg::DATA_W-1:0]  velocity_o,
  output logic signed [tmp_pkg::DATA_W-1:0]  acceleration_o,
  output logic [tmp_pkg::PHASE_W-1:0]        phase_o,
  output logic [tmp_pkg::REG_W-1:0]          total_time_o,
  output logic                               triangular_o
);
  import tmp_pkg::*;

  // sequencer: plan path, shared square and product steps, sample path
  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001,
    ST_P_VSQ  = 20'h00002,
    ST_P_DA   = 20'h00004,
    ST_P_CMP  = 20'h00008,
    ST_DIV    = 20'h00010,
    ST_SQ_MUL = 20'h00020,
    ST_SQ_CMP = 20'h00040,
    ST_P_PK   = 20'h00080,
    ST_P_D2   = 20'h00100,
    ST_P_END  = 20'h00200,
    ST_SMP    = 20'h00400,
    ST_LIN    = 20'h00800,
    ST_LIN1   = 20'h01000,
    ST_SQ0    = 20'h02000,
    ST_SQ1    = 20'h04000,
    ST_SQ2    = 20'h08000,
    ST_SQ3    = 20'h10000,
    ST_VEL    = 20'h20000,
    ST_VEL1   = 20'h40000,
    ST_FIN    = 20'h80000
  } state_e;

  // which quotient the divider is working on
  typedef enum logic [1:0] {
    DS_ROOT = 2'd0,
    DS_DACC = 2'd1,
    DS_TACC = 2'd2,
    DS_TCRU = 2'd3
  } div_step_e;

  function automatic logic [REG_W-1:0] cap31(input logic [63:0] v);
    logic [REG_W-1:0] r;
    r = (v > 64'h7fff_ffff) ? 31'h7fff_ffff : v[REG_W-1:0];
    return r;
  endfunction

  // magnitude and sign to saturated two's complement
  function automatic logic [DATA_W-1:0] to_s32(input logic [63:0] mag, input logic neg);
    logic [DATA_W-1:0] r;
    if (neg) begin
      r = (mag > 64'h8000_0000) ? 32'h8000_0000 : mag[DATA_W-1:0];
      r = 32'd0 - r;
    end else begin
      r = (mag > 64'h7fff_ffff) ? 32'h7fff_ffff : mag[DATA_W-1:0];
    end
    return r;
  endfunction

  state_e      state_q, state_d;
  div_step_e   step_q, step_d;

  // configuration
  logic [REG_W-1:0] vmax_q, vmax_d, amax_q, amax_d;
  logic [REG_W-1:0] vmax_e, amax_e;

  // stored plan
  logic              sign_q, sign_d;
  logic [DATA_W-1:0] absd_q, absd_d;
  logic [REG_W-1:0]  ta_q, ta_d, ct_q, ct_d, pk_q, pk_d, tot_q, tot_d;
  logic [DATA_W-1:0] d1_q, d1_d, d2_q, d2_d;

  // working registers
  logic              op_q, op_d, negin_q, negin_d, tri_q, tri_d;
  logic [DATA_W-1:0] dist_q, dist_d, t_q, t_d;
  logic [63:0]       vsq_q, vsq_d, prod_q, prod_d, q_q, q_d;
  logic [REG_W-1:0]  r_q, r_d;
  logic [4:0]        bit_q, bit_d;
  logic [PHASE_W-1:0] ph_q, ph_d;
  logic              facc_q, facc_d, fdec_q, fdec_d;
  logic [REG_W-1:0]  x_q, x_d, vx_q, vx_d;
  logic [63:0]       tt_q, tt_d, lo_q, lo_d, aterm_q, aterm_d, p_q, p_d, vel_q, vel_d;

  // output register
  logic              ovalid_q, ovalid_d;
  logic [DATA_W-1:0] opos_q, opos_d, ovel_q, ovel_d, oacc_q, oacc_d;
  logic [PHASE_W-1:0] oph_q, oph_d;
  logic [REG_W-1:0]  otot_q, otot_d;
  logic              otri_q, otri_d;

  // shared multiplier and divider hookup
  logic [31:0]       mul_a, mul_b;
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_dvd, div_quo;
  logic [DSR_W-1:0]  div_dsr;

  logic [REG_W-1:0]  root_c, ts;
  logic [DATA_W-1:0] tc;
  logic [95:0]       hsum;
  logic [63:0]       pos_mag, vel_mag;

  tmp_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // a zero register acts as one lsb
  assign vmax_e = (vmax_q == '0) ? REG_W'(1) : vmax_q;
  assign amax_e = (amax_q == '0) ? REG_W'(1) : amax_q;

  assign root_c = r_q | (REG_W'(1) << bit_q);
  assign ts     = t_q[REG_W-1:0];
  assign tc     = {1'b0, ta_q} + {1'b0, ct_q};
  assign hsum   = ({32'd0, prod_q} << 32) + {32'd0, lo_q};

  // operand selection for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_P_VSQ:  begin mul_a = {1'b0, vmax_e}; mul_b = {1'b0, vmax_e}; end
      ST_P_DA:   begin mul_a = dist_q;         mul_b = {1'b0, amax_e}; end
      ST_SQ_MUL: begin mul_a = {1'b0, root_c}; mul_b = {1'b0, root_c}; end
      ST_P_PK:   begin mul_a = {1'b0, r_q};    mul_b = {1'b0, amax_e}; end
      ST_P_D2:   begin mul_a = {1'b0, vmax_e}; mul_b = {1'b0, ct_q};   end
      ST_SQ0:    begin mul_a = {1'b0, x_q};    mul_b = {1'b0, x_q};    end
      ST_SQ1:    begin mul_a = prod_q[31:0];   mul_b = {1'b0, amax_e}; end
      ST_SQ2:    begin mul_a = tt_q[63:32];    mul_b = {1'b0, amax_e}; end
      ST_LIN:    begin mul_a = {1'b0, pk_q};   mul_b = {1'b0, x_q};    end
      ST_VEL:    begin mul_a = {1'b0, amax_e}; mul_b = {1'b0, vx_q};   end
      default:   begin mul_a = '0;             mul_b = '0;             end
    endcase
    prod_d = 64'(mul_a) * 64'(mul_b);
  end

  // result magnitudes of a sample
  always_comb begin
    pos_mag = '0;
    vel_mag = '0;
    if (ph_q == PH_FINISHED) begin
      pos_mag = 64'(absd_q);
    end else if (ph_q != PH_BEFORE) begin
      if (facc_q) begin
        pos_mag = aterm_q;
      end else if (fdec_q) begin
        pos_mag = (p_q > aterm_q) ? (p_q - aterm_q) : 64'd0;
      end else begin
        pos_mag = p_q;
      end
      vel_mag = (facc_q || fdec_q) ? vel_q : 64'(pk_q);
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    vmax_d   = vmax_q;
    amax_d   = amax_q;
    sign_d   = sign_q;
    absd_d   = absd_q;
    ta_d     = ta_q;
    ct_d     = ct_q;
    pk_d     = pk_q;
    tot_d    = tot_q;
    d1_d     = d1_q;
    d2_d     = d2_q;
    op_d     = op_q;
    negin_d  = negin_q;
    tri_d    = tri_q;
    dist_d   = dist_q;
    t_d      = t_q;
    vsq_d    = vsq_q;
    q_d      = q_q;
    r_d      = r_q;
    bit_d    = bit_q;
    ph_d     = ph_q;
    facc_d   = facc_q;
    fdec_d   = fdec_q;
    x_d      = x_q;
    vx_d     = vx_q;
    tt_d     = tt_q;
    lo_d     = lo_q;
    aterm_d  = aterm_q;
    p_d      = p_q;
    vel_d    = vel_q;
    ovalid_d = ovalid_q && !out_ready_i;
    opos_d   = opos_q;
    ovel_d   = ovel_q;
    oacc_d   = oacc_q;
    oph_d    = oph_q;
    otot_d   = otot_q;
    otri_d   = otri_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_VMAX: vmax_d = cfg_data_i;
        CFG_AMAX: amax_d = cfg_data_i;
        default:  vmax_d = vmax_q;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          t_d     = sample_time_i;
          negin_d = move_distance_i[DATA_W-1];
          dist_d  = move_distance_i[DATA_W-1] ? (32'd0 - move_distance_i) : move_distance_i;
          state_d = (operation_i == OP_PLAN) ? ST_P_VSQ : ST_SMP;
        end
      end
      ST_P_VSQ: state_d = ST_P_DA;
      ST_P_DA: begin
        vsq_d   = prod_q;
        state_d = ST_P_CMP;
      end
      ST_P_CMP: begin
        // triangular when the move is too short to reach cruise speed
        tri_d     = prod_q < vsq_q;
        div_start = 1'b1;
        if (prod_q < vsq_q) begin
          div_dvd = 64'(dist_q) << (2 * FRAC_BITS);
          div_dsr = DSR_W'(amax_e);
          step_d  = DS_ROOT;
        end else begin
          div_dvd = vsq_q;
          div_dsr = {1'b0, amax_e, 1'b0};
          step_d  = DS_DACC;
        end
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          case (step_q)
            DS_ROOT: begin
              q_d     = div_quo;
              r_d     = '0;
              bit_d   = 5'd30;
              state_d = ST_SQ_MUL;
            end
            DS_DACC: begin
              d1_d      = div_quo[DATA_W-1:0];
              div_start = 1'b1;
              div_dvd   = 64'(vmax_e) << FRAC_BITS;
              div_dsr   = DSR_W'(amax_e);
              step_d    = DS_TACC;
            end
            DS_TACC: begin
              ta_d      = cap31(div_quo);
              div_start = 1'b1;
              div_dvd   = 64'(dist_q - {d1_q[DATA_W-2:0], 1'b0}) << FRAC_BITS;
              div_dsr   = DSR_W'(vmax_e);
              step_d    = DS_TCRU;
            end
            DS_TCRU: begin
              ct_d    = cap31(div_quo);
              state_d = ST_P_D2;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      // integer root of the quotient, one bit per multiply
      ST_SQ_MUL: state_d = ST_SQ_CMP;
      ST_SQ_CMP: begin
        if (prod_q <= q_q) begin
          r_d = root_c;
        end
        if (bit_q == '0) begin
          state_d = ST_P_PK;
        end else begin
          bit_d   = bit_q - 1'b1;
          state_d = ST_SQ_MUL;
        end
      end
      ST_P_PK: state_d = ST_P_END;
      ST_P_D2: state_d = ST_P_END;
      ST_P_END: begin
        if (tri_q) begin
          ta_d  = r_q;
          ct_d  = '0;
          pk_d  = cap31(prod_q >> FRAC_BITS);
          d1_d  = dist_q >> 1;
          d2_d  = '0;
          tot_d = cap31(64'(r_q) << 1);
        end else begin
          d2_d  = DATA_W'(prod_q >> FRAC_BITS);
          pk_d  = vmax_e;
          tot_d = cap31((64'(ta_q) << 1) + 64'(ct_q));
        end
        sign_d  = negin_q;
        absd_d  = dist_q;
        state_d = ST_FIN;
      end
      ST_SMP: begin
        facc_d = 1'b0;
        fdec_d = 1'b0;
        if (t_q[DATA_W-1]) begin
          ph_d    = PH_BEFORE;
          state_d = ST_FIN;
        end else if (ts > tot_q) begin
          ph_d    = PH_FINISHED;
          state_d = ST_FIN;
        end else begin
          if (ts < ta_q) begin
            ph_d = PH_ACCEL;
          end else if ({1'b0, ts} < tc) begin
            ph_d = PH_CRUISE;
          end else begin
            ph_d = PH_DECEL;
          end
          if (ts < ta_q) begin
            facc_d  = 1'b1;
            x_d     = ts;
            vx_d    = ts;
            state_d = ST_SQ0;
          end else if ({1'b0, ts} > tc) begin
            fdec_d  = 1'b1;
            x_d     = ts - tc[REG_W-1:0];
            vx_d    = tot_q - ts;
            state_d = ST_LIN;
          end else begin
            x_d     = ts - ta_q;
            state_d = ST_LIN;
          end
        end
      end
      ST_LIN: state_d = ST_LIN1;
      ST_LIN1: begin
        p_d     = 64'(d1_q) + (prod_q >> FRAC_BITS) + (fdec_q ? 64'(d2_q) : 64'd0);
        state_d = fdec_q ? ST_SQ0 : ST_FIN;
      end
      // half a times x squared, product split in two halves
      ST_SQ0: state_d = ST_SQ1;
      ST_SQ1: begin
        tt_d    = prod_q;
        state_d = ST_SQ2;
      end
      ST_SQ2: begin
        lo_d    = prod_q;
        state_d = ST_SQ3;
      end
      ST_SQ3: begin
        aterm_d = 64'(hsum >> (2 * FRAC_BITS + 1));
        state_d = ST_VEL;
      end
      ST_VEL: state_d = ST_VEL1;
      ST_VEL1: begin
        vel_d   = prod_q >> FRAC_BITS;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          if (op_q == OP_PLAN) begin
            opos_d = '0;
            ovel_d = '0;
            oacc_d = '0;
            oph_d  = PH_BEFORE;
            otot_d = tot_q;
            otri_d = tri_q;
          end else begin
            opos_d = to_s32(pos_mag, sign_q);
            ovel_d = to_s32(vel_mag, sign_q);
            case (ph_q)
              PH_ACCEL: oacc_d = to_s32(64'(amax_e), sign_q);
              PH_DECEL: oacc_d = to_s32(64'(amax_e), !sign_q);
              default:  oacc_d = '0;
            endcase
            oph_d  = ph_q;
            otot_d = '0;
            otri_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= DS_ROOT;
      vmax_q   <= REG_ONE;
      amax_q   <= REG_ONE;
      sign_q   <= 1'b0;
      absd_q   <= '0;
      ta_q     <= '0;
      ct_q     <= '0;
      pk_q     <= '0;
      tot_q    <= '0;
      d1_q     <= '0;
      d2_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      vmax_q   <= vmax_d;
      amax_q   <= amax_d;
      sign_q   <= sign_d;
      absd_q   <= absd_d;
      ta_q     <= ta_d;
      ct_q     <= ct_d;
      pk_q     <= pk_d;
      tot_q    <= tot_d;
      d1_q     <= d1_d;
      d2_q     <= d2_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    negin_q <= negin_d;
    tri_q   <= tri_d;
    dist_q  <= dist_d;
    t_q     <= t_d;
    vsq_q   <= vsq_d;
    prod_q  <= prod_d;
    q_q     <= q_d;
    r_q     <= r_d;
    bit_q   <= bit_d;
    ph_q    <= ph_d;
    facc_q  <= facc_d;
    fdec_q  <= fdec_d;
    x_q     <= x_d;
    vx_q    <= vx_d;
    tt_q    <= tt_d;
    lo_q    <= lo_d;
    aterm_q <= aterm_d;
    p_q     <= p_d;
    vel_q   <= vel_d;
    opos_q  <= opos_d;
    ovel_q  <= ovel_d;
    oacc_q  <= oacc_d;
    oph_q   <= oph_d;
    otot_q  <= otot_d;
    otri_q  <= otri_d;
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = ovalid_q;
  assign position_o     = opos_q;
  assign velocity_o     = ovel_q;
  assign acceleration_o = oacc_q;
  assign phase_o        = oph_q;
  assign total_time_o   = otot_q;
  assign triangular_o   = otri_q;

  `TMP_ASSERT(a_total_covers_accel, (state_q == ST_IDLE) |-> (tot_q >= ta_q))
  `TMP_ASSERT(a_finished_at_rest, (ovalid_q && oph_q == PH_FINISHED) |-> (ovel_q == '0 && oacc_q == '0))
  `TMP_ASSERT(a_plan_no_phase, (ovalid_q && otri_q) |-> (oph_q == PH_BEFORE))

endmodule
